[sv/framed_byte_receive_fifo_macros.svh]
// assertion macros for the framed byte receive fifo
`ifndef FRAMED_BYTE_RECEIVE_FIFO_MACROS_SVH
`define FRAMED_BYTE_RECEIVE_FIFO_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FBRF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fbrf assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define FBRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fbrf assertion failed");

`endif

[sv/fbrf_pkg.sv]
// shared types and constants for the framed byte receive fifo
package fbrf_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int HELD_W     = $clog2(FIFO_DEPTH + 1);
  localparam int COUNT_W    = 5;

  localparam logic [7:0] START_DELIM_RST = 8'd60;
  localparam logic [7:0] END_DELIM_RST   = 8'd62;
  localparam logic [7:0] HEARTBEAT_RST   = 8'd72;
  localparam logic [7:0] EMPTY_CODE_RST  = 8'd0;

  typedef enum logic [1:0] {
    REG_START_DELIM = 2'd0,
    REG_END_DELIM   = 2'd1,
    REG_HEARTBEAT   = 2'd2,
    REG_EMPTY_CODE  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    MODE_RECEIVE = 1'b0,
    MODE_CONSUME = 1'b1
  } mode_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic               fifo_was_empty;
    logic               overflow;
    logic               heartbeat_seen;
    logic               led_state;
    logic [COUNT_W-1:0] fill_count;
  } out_item_t;

endpackage

[sv/framed_byte_receive_fifo.sv]
// framed byte receiver feeding a 16-entry ring fifo, one result per item
//
// Input channel (in_valid, in_stall, in_data): each transfer is either a
// received byte (mode 0) or a request to pop the oldest buffered byte (mode 1).
// Bytes outside a frame only look for the start delimiter; inside a frame the
// end delimiter closes it, the heartbeat byte toggles the led bit and raises
// heartbeat_seen, and any other byte is pushed. A full fifo drops any byte, even
// a delimiter, and flags overflow. A pop of an empty fifo returns the empty code.
// Output channel (out_valid, out_stall, out_data): exactly one result per item.
// Results are registered: an item taken at one edge shows its result in the
// output register right after it. Throughput is one item per cycle while in_stall is
// low; all work is a compare and a pointer update ahead of the output register.
// When the receiver stalls, the result holds in the output register and
// in_stall rises, so no item is taken until that result is transferred.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
// and belong in idle periods. Synchronous reset empties the fifo, closes the
// frame, clears the led bit and restores the default delimiters.
module framed_byte_receive_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  fbrf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fbrf_pkg::out_item_t out_data
);

  logic [7:0] start_delim;
  logic [7:0] end_delim;
  logic [7:0] heartbeat;
  logic [7:0] empty_code;

  logic                        in_frame, in_frame_next;
  logic                        led_bit, led_bit_next;
  logic [fbrf_pkg::PTR_W-1:0]  write_pointer, write_pointer_next;
  logic [fbrf_pkg::PTR_W-1:0]  read_pointer, read_pointer_next;
  logic [fbrf_pkg::HELD_W-1:0] byte_count, byte_count_next;
  logic [7:0]                  fifo_store [fbrf_pkg::FIFO_DEPTH];

  logic                accept;
  logic                push;
  logic                pop;
  logic                fifo_full;
  fbrf_pkg::out_item_t result;

  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign fifo_full = (byte_count == fbrf_pkg::HELD_W'(fbrf_pkg::FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      start_delim <= fbrf_pkg::START_DELIM_RST;
      end_delim   <= fbrf_pkg::END_DELIM_RST;
      heartbeat   <= fbrf_pkg::HEARTBEAT_RST;
      empty_code  <= fbrf_pkg::EMPTY_CODE_RST;
    end else if (cfg_write) begin
      unique case (fbrf_pkg::cfg_reg_t'(cfg_index))
        fbrf_pkg::REG_START_DELIM: start_delim <= cfg_data;
        fbrf_pkg::REG_END_DELIM:   end_delim   <= cfg_data;
        fbrf_pkg::REG_HEARTBEAT:   heartbeat   <= cfg_data;
        fbrf_pkg::REG_EMPTY_CODE:  empty_code  <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [fbrf_pkg::PTR_W-1:0] next_index(
    input logic [fbrf_pkg::PTR_W-1:0] p
  );
    if (p == fbrf_pkg::PTR_W'(fbrf_pkg::FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    in_frame_next      = in_frame;
    led_bit_next       = led_bit;
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    byte_count_next    = byte_count;
    push               = 1'b0;
    pop                = 1'b0;
    result             = '0;
    if (in_data.mode == fbrf_pkg::MODE_RECEIVE) begin
      priority if (byte_count >= fbrf_pkg::HELD_W'(fbrf_pkg::FIFO_DEPTH)) begin
        // full: dropped whatever the byte is
        result.overflow = 1'b1;
      end else if (!in_frame) begin
        if (in_data.rx_byte == start_delim) begin
          in_frame_next = 1'b1;
        end
      end else if (in_data.rx_byte == end_delim) begin
        in_frame_next = 1'b0;
      end else if (in_data.rx_byte == heartbeat) begin
        led_bit_next          = ~led_bit;
        result.heartbeat_seen = 1'b1;
      end else begin
        push               = 1'b1;
        write_pointer_next = next_index(write_pointer);
        byte_count_next    = byte_count + 1'b1;
      end
    end else begin
      if (byte_count == '0) begin
        result.read_data      = empty_code;
        result.fifo_was_empty = 1'b1;
      end else begin
        pop               = 1'b1;
        read_pointer_next = next_index(read_pointer);
        byte_count_next   = byte_count - 1'b1;
      end
    end
    result.led_state  = led_bit_next;
    result.fill_count = fbrf_pkg::COUNT_W'(byte_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      led_bit       <= 1'b0;
      write_pointer <= '0;
      read_pointer  <= '0;
      byte_count    <= '0;
    end else if (accept) begin
      in_frame      <= in_frame_next;
      led_bit       <= led_bit_next;
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      byte_count    <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push) begin
      fifo_store[write_pointer] <= in_data.rx_byte;
    end
  end

  // output register: reloads whenever the held result is gone or being transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      // a popped byte is read from the store straight into the output register
      out_data.read_data      <= pop ? fifo_store[read_pointer] : result.read_data;
      out_data.fifo_was_empty <= result.fifo_was_empty;
      out_data.overflow       <= result.overflow;
      out_data.heartbeat_seen <= result.heartbeat_seen;
      out_data.led_state      <= result.led_state;
      out_data.fill_count     <= result.fill_count;
    end
  end

`include "framed_byte_receive_fifo_macros.svh"

  `FBRF_ASSERT_NOW(a_count_bound, 1'b1, byte_count <= fbrf_pkg::HELD_W'(fbrf_pkg::FIFO_DEPTH))
  `FBRF_ASSERT_NOW(a_ptr_match, (byte_count == '0) || fifo_full, write_pointer == read_pointer)
  `FBRF_ASSERT_NOW(a_overflow_full, out_valid && out_data.overflow, fifo_full)
  `FBRF_ASSERT_NEXT(a_count_hold, !accept, $stable(byte_count) && $stable(read_pointer))

endmodule

[tb/sv/framed_byte_receive_fifo_test.sv]
// testbench for the framed byte receive fifo: directed and random traffic against a mirror model
module framed_byte_receive_fifo_test;
  timeunit 1ns;
  timeprecision 1ps;

  // mirror of the framer and ring fifo, holds the replies still owed by the block
  class framed_fifo_mirror;
    logic [7:0]          start_delim;
    logic [7:0]          end_delim;
    logic [7:0]          heartbeat;
    logic [7:0]          empty_code;
    bit                  in_frame;
    bit                  led;
    logic [7:0]          store [fbrf_pkg::FIFO_DEPTH];
    int unsigned         wr_ptr;
    int unsigned         rd_ptr;
    int unsigned         held;
    fbrf_pkg::out_item_t replies [$];
    int unsigned         errors;
    int unsigned         items;
    int unsigned         checked;
    int unsigned         overflows;
    int unsigned         heartbeats;
    int unsigned         empty_pops;

    function new();
      start_delim = fbrf_pkg::START_DELIM_RST;
      end_delim   = fbrf_pkg::END_DELIM_RST;
      heartbeat   = fbrf_pkg::HEARTBEAT_RST;
      empty_code  = fbrf_pkg::EMPTY_CODE_RST;
      in_frame    = 1'b0;
      led         = 1'b0;
      wr_ptr      = 0;
      rd_ptr      = 0;
      held        = 0;
      errors      = 0;
      items       = 0;
      checked     = 0;
      overflows   = 0;
      heartbeats  = 0;
      empty_pops  = 0;
    endfunction

    function void set_reg(fbrf_pkg::cfg_reg_t idx, logic [7:0] v);
      case (idx)
        fbrf_pkg::REG_START_DELIM: start_delim = v;
        fbrf_pkg::REG_END_DELIM:   end_delim = v;
        fbrf_pkg::REG_HEARTBEAT:   heartbeat = v;
        fbrf_pkg::REG_EMPTY_CODE:  empty_code = v;
        default: ;
      endcase
    endfunction

    function int unsigned replies_owed();
      return replies.size();
    endfunction

    function void take_item(fbrf_pkg::in_item_t it);
      fbrf_pkg::out_item_t res;
      res = '0;
      items++;
      if (it.mode == fbrf_pkg::MODE_RECEIVE) begin
        // a full fifo drops the byte before any framing decision
        if (held >= fbrf_pkg::FIFO_DEPTH) begin
          res.overflow = 1'b1;
        end else if (!in_frame) begin
          if (it.rx_byte == start_delim) in_frame = 1'b1;
        end else if (it.rx_byte == end_delim) begin
          in_frame = 1'b0;
        end else if (it.rx_byte == heartbeat) begin
          led = !led;
          res.heartbeat_seen = 1'b1;
        end else begin
          store[wr_ptr] = it.rx_byte;
          wr_ptr = (wr_ptr + 1) % fbrf_pkg::FIFO_DEPTH;
          held++;
        end
      end else if (held == 0) begin
        res.read_data = empty_code;
        res.fifo_was_empty = 1'b1;
      end else begin
        res.read_data = store[rd_ptr];
        rd_ptr = (rd_ptr + 1) % fbrf_pkg::FIFO_DEPTH;
        held--;
      end
      res.led_state = led;
      res.fill_count = fbrf_pkg::COUNT_W'(held);
      replies.push_back(res);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_reply(fbrf_pkg::out_item_t got);
      fbrf_pkg::out_item_t want;
      if (replies.size() == 0) begin
        $error("result transfer with no item outstanding");
        errors++;
        return;
      end
      want = replies.pop_front();
      checked++;
      if (want.overflow) overflows++;
      if (want.heartbeat_seen) heartbeats++;
      if (want.fifo_was_empty) empty_pops++;
      check_field("read_data", want.read_data, got.read_data);
      check_field("fifo_was_empty", want.fifo_was_empty, got.fifo_was_empty);
      check_field("overflow", want.overflow, got.overflow);
      check_field("heartbeat_seen", want.heartbeat_seen, got.heartbeat_seen);
      check_field("led_state", want.led_state, got.led_state);
      check_field("fill_count", want.fill_count, got.fill_count);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [7:0]          cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  fbrf_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  fbrf_pkg::out_item_t out_data;

  framed_fifo_mirror mirror;
  int idle_pct = 0;
  int stall_pct = 0;
  int settings = 0;

  framed_byte_receive_fifo dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("framed_byte_receive_fifo_test: FAIL");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // sample both channels before the block's own updates at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) mirror.take_item(in_data);
      if (out_valid && !out_stall) mirror.match_reply(out_data);
    end
  end

  task automatic send_item(input fbrf_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_rx(input logic [7:0] b);
    fbrf_pkg::in_item_t it;
    it.mode = fbrf_pkg::MODE_RECEIVE;
    it.rx_byte = b;
    send_item(it);
  endtask

  task automatic send_pop(input logic [7:0] junk);
    fbrf_pkg::in_item_t it;
    it.mode = fbrf_pkg::MODE_CONSUME;
    it.rx_byte = junk;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (mirror.replies_owed() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input fbrf_pkg::cfg_reg_t idx, input logic [7:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    mirror.set_reg(idx, v);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_setting(input logic [7:0] s, input logic [7:0] e,
                              input logic [7:0] h, input logic [7:0] c);
    write_reg(fbrf_pkg::REG_START_DELIM, s);
    write_reg(fbrf_pkg::REG_END_DELIM, e);
    write_reg(fbrf_pkg::REG_HEARTBEAT, h);
    write_reg(fbrf_pkg::REG_EMPTY_CODE, c);
    settings++;
  endtask

  // mostly well-formed frames with random payload, plus stray bytes and pops
  function automatic fbrf_pkg::in_item_t pick_item(int consume_pct);
    fbrf_pkg::in_item_t it;
    int unsigned r;
    it.rx_byte = 8'($urandom);
    it.mode = fbrf_pkg::MODE_CONSUME;
    r = $urandom_range(99);
    if (r < consume_pct) return it;
    it.mode = fbrf_pkg::MODE_RECEIVE;
    r = $urandom_range(99);
    if (!mirror.in_frame) begin
      if (r < 70) it.rx_byte = mirror.start_delim;
    end else if (r < 8) begin
      it.rx_byte = mirror.end_delim;
    end else if (r < 18) begin
      it.rx_byte = mirror.heartbeat;
    end else if (r < 23) begin
      it.rx_byte = mirror.start_delim;
    end
    return it;
  endfunction

  initial begin
    int phase;
    int n;
    logic [7:0] shared;
    mirror = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed pass at the reset register values
    send_pop(8'hFF);
    send_rx(fbrf_pkg::HEARTBEAT_RST);
    send_rx(fbrf_pkg::END_DELIM_RST);
    send_rx(8'h00);
    send_rx(fbrf_pkg::START_DELIM_RST);
    send_rx(fbrf_pkg::START_DELIM_RST);
    send_rx(8'hFF);
    send_rx(8'h00);
    send_rx(fbrf_pkg::HEARTBEAT_RST);
    for (n = 0; n < 13; n++) send_rx(8'h10 + 8'(n));
    // fifo is full: delimiters and heartbeat are dropped too
    send_rx(fbrf_pkg::END_DELIM_RST);
    send_rx(fbrf_pkg::HEARTBEAT_RST);
    send_pop(8'h00);
    send_rx(fbrf_pkg::END_DELIM_RST);
    wait_drained();

    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      shared = 8'($urandom);
      case (phase)
        0: load_setting(fbrf_pkg::START_DELIM_RST, fbrf_pkg::END_DELIM_RST,
                        fbrf_pkg::HEARTBEAT_RST, fbrf_pkg::EMPTY_CODE_RST);
        1: load_setting(8'h00, 8'hFF, 8'h80, 8'hFF);
        // heartbeat equal to end delimiter, the close must win
        2: load_setting(8'hFF, 8'h00, 8'h00, 8'hA5);
        3: load_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        4: load_setting(shared, shared, shared, 8'($urandom));
        5: load_setting(8'h00, 8'h00, 8'hFF, 8'h00);
        6: load_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        default: load_setting(fbrf_pkg::START_DELIM_RST, fbrf_pkg::END_DELIM_RST,
                              fbrf_pkg::HEARTBEAT_RST, 8'h5A);
      endcase
      for (n = 0; n < 75; n++) begin
        if (phase == 3 && n == 40) wait_drained();
        send_item(pick_item((phase % 2) ? 55 : 30));
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (mirror.replies_owed() != 0) begin
      $error("%0d results never arrived", mirror.replies_owed());
      mirror.errors++;
    end
    $display("ran %0d items, checked %0d results under %0d register settings",
             mirror.items, mirror.checked, settings);
    $display("saw %0d dropped bytes, %0d heartbeats and %0d pops of an empty fifo",
             mirror.overflows, mirror.heartbeats, mirror.empty_pops);
    if (mirror.errors == 0) begin
      $display("framed_byte_receive_fifo_test: PASS");
    end else begin
      $display("framed_byte_receive_fifo_test: FAIL");
    end
    $finish;
  end

endmodule

[framed_byte_receive_fifo.f]
+incdir+sv
sv/fbrf_pkg.sv
sv/framed_byte_receive_fifo.sv
tb/sv/framed_byte_receive_fifo_test.sv
